[rtl/core/prf_pkg.sv]
`default_nettype none

package prf_pkg;

  // Field and datapath widths.
  localparam int unsigned POS_WIDTH_DEF = 32;
  localparam int unsigned CUT_W = 24;
  localparam int unsigned MASS_W = 16;
  localparam int unsigned CFG_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned R2_W = 48;
  localparam int unsigned ROOT_W = 24;
  localparam int unsigned SQ_REM_W = 26;
  localparam int unsigned PROD_W = 64;
  localparam int unsigned DEN_W = 72;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned PLOW_W = 16;

  // Register reset values.
  localparam logic [CUT_W-1:0] RST_CUTOFF = 24'd167772;
  localparam logic [CUT_W-1:0] RST_MIN_DIST = 24'd1678;
  localparam logic [MASS_W-1:0] RST_INV_MASS = 16'd100;
  localparam logic [R2_W-1:0] RST_CUTOFF_SQ = R2_W'(RST_CUTOFF) * R2_W'(RST_CUTOFF);
  localparam logic [R2_W-1:0] RST_MIN_SQ = R2_W'(RST_MIN_DIST) * R2_W'(RST_MIN_DIST);

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CUTOFF   = 2'd0,
    CFG_MIN_DIST = 2'd1,
    CFG_INV_MASS = 2'd2
  } cfg_idx_e;

  // Pair geometry after the front end.
  typedef struct packed {
    logic [CUT_W-1:0] ax;
    logic [CUT_W-1:0] ay;
    logic             xneg;
    logic             yneg;
    logic             in_range;
    logic [R2_W-1:0]  r2;
  } front_t;

  // One stage of the square root pipeline.
  typedef struct packed {
    front_t              f;
    logic [R2_W-1:0]     rad;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
  } sqrt_st_t;

  // Operands of one axis division.
  typedef struct packed {
    logic [PROD_W-1:0] p;
    logic [DEN_W-1:0]  den;
    logic              neg;
    logic              in_range;
  } div_in_t;

  typedef struct packed {
    div_in_t x;
    div_in_t y;
  } prep_out_t;

  // One stage of the restoring divider.
  typedef struct packed {
    logic [DEN_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [PLOW_W-1:0] plow;
    logic [ACC_W-1:0]  q;
    logic              ovf;
    logic              neg;
    logic              in_range;
  } div_st_t;

  // One result bit of the integer square root.
  function automatic sqrt_st_t sqrt_step(sqrt_st_t s);
    sqrt_st_t r;
    logic [SQ_REM_W+1:0] x;
    logic [SQ_REM_W+1:0] t;
    r = s;
    x = {s.rem, s.rad[R2_W-1 -: 2]};
    t = {2'b00, s.root, 2'b01};
    r.rad = {s.rad[R2_W-3:0], 2'b00};
    if (x >= t) begin
      r.rem = SQ_REM_W'(x - t);
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem = x[SQ_REM_W-1:0];
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // One quotient bit of the restoring division.
  function automatic div_st_t div_step(div_st_t s);
    div_st_t r;
    logic [DEN_W:0] sh;
    r = s;
    sh = {s.rem, s.plow[PLOW_W-1]};
    r.plow = {s.plow[PLOW_W-2:0], 1'b0};
    if (sh >= {1'b0, s.den}) begin
      r.rem = DEN_W'(sh - {1'b0, s.den});
      r.q = {s.q[ACC_W-2:0], 1'b1};
    end else begin
      r.rem = sh[DEN_W-1:0];
      r.q = {s.q[ACC_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // Signed result with saturation; pairs out of range give zero.
  function automatic logic [ACC_W-1:0] sat_acc(div_st_t s);
    logic [ACC_W-1:0] res;
    if (!s.in_range) begin
      res = '0;
    end else if (!s.neg) begin
      res = (s.ovf || s.q[ACC_W-1]) ? ACC_MAX : s.q;
    end else begin
      res = (s.ovf || (s.q > ACC_MIN)) ? ACC_MIN : (~s.q + ACC_W'(1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/core/prf_if.sv]
`default_nettype none

// Pair positions going into the core.
interface prf_in_if import prf_pkg::*; #(
  parameter int unsigned POS_W = POS_WIDTH_DEF
) ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] self_x;
  logic [POS_W-1:0] self_y;
  logic [POS_W-1:0] other_x;
  logic [POS_W-1:0] other_y;

  modport source(output valid, self_x, self_y, other_x, other_y, input ready);
  modport sink(input valid, self_x, self_y, other_x, other_y, output ready);
endinterface

// Acceleration increments coming out of the core.
interface prf_out_if import prf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ACC_W-1:0] accel_x;
  logic [ACC_W-1:0] accel_y;
  logic             within_cutoff;

  modport source(output valid, accel_x, accel_y, within_cutoff, input ready);
  modport sink(input valid, accel_x, accel_y, within_cutoff, output ready);
endinterface

`default_nettype wire

[rtl/core/pair_repulsive_force_core.sv]
// Short-range repulsive pair force. Each transfer on in_ch carries the
// positions of a particle and one neighbor (unsigned Q8.24); each transfer on
// out_ch carries the x and y acceleration increments (signed Q40.24,
// saturating) and a flag that tells whether the pair lies within the cutoff.
// Pairs beyond the cutoff give zero increments. One pair is accepted every
// clock cycle while the front end is not stalled; a result passes through
// separation and squaring, a square root at one root bit per stage,
// products, and the two axis dividers, which produce one quotient bit per
// stage. A stalled output freezes every stage of a section whose last stage
// holds a waiting pair, bubbles included; a section whose last stage is
// empty keeps moving. Registers: 0 cutoff distance (Q8.24), 1 minimum
// distance (Q8.24), 2 inverse mass; write them only while no pair is in
// flight, and allow two cycles before the next pair.
`default_nettype none

module pair_repulsive_force_core import prf_pkg::*; #(
  parameter int unsigned POS_WIDTH = POS_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i,
  prf_in_if.sink                    in_ch,
  prf_out_if.source                 out_ch
);

  logic [CUT_W-1:0]  cutoff_q, min_dist_q, min_eff;
  logic [MASS_W-1:0] inv_mass_q;
  logic [R2_W-1:0]   cutoff_sq_q, min_sq_q;

  logic              f_valid, f_ready;
  front_t            f_data;
  logic              s_valid, s_ready;
  sqrt_st_t          s_data;
  logic              p_valid, p_ready;
  prep_out_t         p_data;
  logic              dx_ready, dy_ready, dx_valid, dy_valid;
  logic [ACC_W-1:0]  acc_x, acc_y;
  logic              rng_x, rng_y;
  logic [POS_WIDTH-1:0] sx, sy, ox, oy;

  // Configuration registers and their squares.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q <= RST_CUTOFF;
      min_dist_q <= RST_MIN_DIST;
      inv_mass_q <= RST_INV_MASS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_CUTOFF:   cutoff_q <= cfg_data_i[CUT_W-1:0];
        CFG_MIN_DIST: min_dist_q <= cfg_data_i[CUT_W-1:0];
        CFG_INV_MASS: inv_mass_q <= cfg_data_i[MASS_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero minimum distance acts as one, so the root never becomes zero.
  assign min_eff = (min_dist_q == '0) ? CUT_W'(1) : min_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_sq_q <= RST_CUTOFF_SQ;
      min_sq_q <= RST_MIN_SQ;
    end else begin
      cutoff_sq_q <= R2_W'(cutoff_q) * R2_W'(cutoff_q);
      min_sq_q <= R2_W'(min_eff) * R2_W'(min_eff);
    end
  end

  assign sx = POS_WIDTH'(in_ch.self_x);
  assign sy = POS_WIDTH'(in_ch.self_y);
  assign ox = POS_WIDTH'(in_ch.other_x);
  assign oy = POS_WIDTH'(in_ch.other_y);

  prf_front #(
    .POS_W (POS_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cutoff_i    (cutoff_q),
    .cutoff_sq_i (cutoff_sq_q),
    .min_sq_i    (min_sq_q),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ch.ready),
    .self_x_i    (sx),
    .self_y_i    (sy),
    .other_x_i   (ox),
    .other_y_i   (oy),
    .out_valid_o (f_valid),
    .out_ready_i (f_ready),
    .out_data_o  (f_data)
  );

  prf_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_data_i   (f_data),
    .out_valid_o (s_valid),
    .out_ready_i (s_ready),
    .out_data_o  (s_data)
  );

  prf_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cutoff_i    (cutoff_q),
    .inv_mass_i  (inv_mass_q),
    .in_valid_i  (s_valid),
    .in_ready_o  (s_ready),
    .in_data_i   (s_data),
    .out_valid_o (p_valid),
    .out_ready_i (p_ready),
    .out_data_o  (p_data)
  );

  // Both axis dividers run in lockstep.
  assign p_ready = dx_ready && dy_ready;

  prf_div u_div_x (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (p_valid),
    .in_ready_o     (dx_ready),
    .in_data_i      (p_data.x),
    .out_valid_o    (dx_valid),
    .out_ready_i    (out_ch.ready),
    .out_acc_o      (acc_x),
    .out_in_range_o (rng_x)
  );

  prf_div u_div_y (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (p_valid),
    .in_ready_o     (dy_ready),
    .in_data_i      (p_data.y),
    .out_valid_o    (dy_valid),
    .out_ready_i    (out_ch.ready),
    .out_acc_o      (acc_y),
    .out_in_range_o (rng_y)
  );

  assign out_ch.valid = dx_valid && dy_valid;
  assign out_ch.accel_x = acc_x;
  assign out_ch.accel_y = acc_y;
  assign out_ch.within_cutoff = rng_x && rng_y;

endmodule

`default_nettype wire

[rtl/core/prf_front.sv]
`default_nettype none

// Separation, cutoff test and clamped squared distance in three stages.
module prf_front import prf_pkg::*; #(
  parameter int unsigned POS_W = POS_WIDTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic [CUT_W-1:0] cutoff_i,
  input  wire logic [R2_W-1:0]  cutoff_sq_i,
  input  wire logic [R2_W-1:0]  min_sq_i,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [POS_W-1:0] self_x_i,
  input  wire logic [POS_W-1:0] self_y_i,
  input  wire logic [POS_W-1:0] other_x_i,
  input  wire logic [POS_W-1:0] other_y_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output front_t                out_data_o
);

  localparam int unsigned CMP_W = (POS_W > CUT_W) ? POS_W : CUT_W;

  logic             en;
  logic [2:0]       v_q;
  logic             xneg_d, yneg_d;
  logic [POS_W-1:0] axw, ayw;
  logic             far_d;
  logic [CUT_W-1:0] ax1_q, ay1_q, ax2_q, ay2_q;
  logic             xn1_q, yn1_q, far1_q, xn2_q, yn2_q, far2_q;
  logic [R2_W-1:0]  sqx_q, sqy_q;
  logic [R2_W:0]    r2_sum;
  front_t           out_d, out_q;

  // The whole front end advances when its last stage can move on.
  assign en = !v_q[2] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[2];
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  // Absolute separation per axis and the per-axis cutoff test.
  assign xneg_d = other_x_i < self_x_i;
  assign yneg_d = other_y_i < self_y_i;
  assign axw = xneg_d ? (self_x_i - other_x_i) : (other_x_i - self_x_i);
  assign ayw = yneg_d ? (self_y_i - other_y_i) : (other_y_i - self_y_i);
  assign far_d = (CMP_W'(axw) > CMP_W'(cutoff_i)) || (CMP_W'(ayw) > CMP_W'(cutoff_i));

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q <= CUT_W'(axw);
      ay1_q <= CUT_W'(ayw);
      xn1_q <= xneg_d;
      yn1_q <= yneg_d;
      far1_q <= far_d;
    end
  end

  // Squares of the separations.
  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q <= R2_W'(ax1_q) * R2_W'(ax1_q);
      sqy_q <= R2_W'(ay1_q) * R2_W'(ay1_q);
      ax2_q <= ax1_q;
      ay2_q <= ay1_q;
      xn2_q <= xn1_q;
      yn2_q <= yn1_q;
      far2_q <= far1_q;
    end
  end

  // Squared distance, radial cutoff test and clamp to the minimum distance.
  assign r2_sum = {1'b0, sqx_q} + {1'b0, sqy_q};

  always_comb begin
    out_d.ax = ax2_q;
    out_d.ay = ay2_q;
    out_d.xneg = xn2_q;
    out_d.yneg = yn2_q;
    out_d.in_range = !far2_q && (r2_sum <= {1'b0, cutoff_sq_i});
    out_d.r2 = (r2_sum < {1'b0, min_sq_i}) ? min_sq_i : r2_sum[R2_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

[rtl/core/prf_sqrt.sv]
`default_nettype none

// Integer square root of the squared distance, one result bit per stage.
module prf_sqrt import prf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire front_t   in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sqrt_st_t      out_data_o
);

  localparam int unsigned NS = ROOT_W;

  logic          en;
  logic [NS-1:0] v_q;
  sqrt_st_t      init;
  sqrt_st_t      st_in [NS];
  sqrt_st_t      st_q [NS];

  assign en = !v_q[NS-1] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[NS-1];
  assign out_data_o = st_q[NS-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NS-2:0], in_valid_i};
    end
  end

  // The radicand is consumed two bits per stage from its top end.
  always_comb begin
    init.f = in_data_i;
    init.rad = in_data_i.r2;
    init.rem = '0;
    init.root = '0;
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k] = init;
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= sqrt_step(st_in[k]);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/prf_prep.sv]
`default_nettype none

// Forms the numerators and the common denominator of both axis divisions.
module prf_prep import prf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [CUT_W-1:0]  cutoff_i,
  input  wire logic [MASS_W-1:0] inv_mass_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sqrt_st_t          in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output prep_out_t              out_data_o
);

  localparam int unsigned P1_W = 2 * CUT_W;

  logic              en;
  logic [2:0]        v_q;
  logic [ROOT_W-1:0] root;
  logic              negr_d;
  logic [CUT_W-1:0]  diff_q;
  logic              negr_q, xn1_q, yn1_q, rng1_q;
  logic [CUT_W-1:0]  ax1_q, ay1_q;
  logic [P1_W-1:0]   dhi_q, dlo_q;
  logic [P1_W-1:0]   px1_q, py1_q;
  logic [DEN_W-1:0]  den2_q;
  logic              nx2_q, ny2_q, rng2_q;
  prep_out_t         out_q;

  assign en = !v_q[2] || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = v_q[2];
  assign out_data_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[1:0], in_valid_i};
    end
  end

  // Distance to the cutoff and the two halves of root times r2.
  assign root = in_data_i.root;
  assign negr_d = root < cutoff_i;

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q <= negr_d ? (cutoff_i - root) : (root - cutoff_i);
      negr_q <= negr_d;
      dhi_q <= P1_W'(root) * P1_W'(in_data_i.f.r2[R2_W-1 -: CUT_W]);
      dlo_q <= P1_W'(root) * P1_W'(in_data_i.f.r2[CUT_W-1:0]);
      ax1_q <= in_data_i.f.ax;
      ay1_q <= in_data_i.f.ay;
      xn1_q <= in_data_i.f.xneg;
      yn1_q <= in_data_i.f.yneg;
      rng1_q <= in_data_i.f.in_range;
    end
  end

  // Separation times cutoff distance, and the full denominator.
  always_ff @(posedge clk_i) begin
    if (en) begin
      px1_q <= P1_W'(diff_q) * P1_W'(ax1_q);
      py1_q <= P1_W'(diff_q) * P1_W'(ay1_q);
      den2_q <= {dhi_q, {CUT_W{1'b0}}} + DEN_W'(dlo_q);
      nx2_q <= negr_q ^ xn1_q;
      ny2_q <= negr_q ^ yn1_q;
      rng2_q <= rng1_q;
    end
  end

  // Scale by the inverse mass.
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.x.p <= PROD_W'(px1_q) * PROD_W'(inv_mass_i);
      out_q.y.p <= PROD_W'(py1_q) * PROD_W'(inv_mass_i);
      out_q.x.den <= den2_q;
      out_q.y.den <= den2_q;
      out_q.x.neg <= nx2_q;
      out_q.y.neg <= ny2_q;
      out_q.x.in_range <= rng2_q;
      out_q.y.in_range <= rng2_q;
    end
  end

endmodule

`default_nettype wire

[rtl/core/prf_div.sv]
`default_nettype none

// One axis: (p * 2^48) / den, one quotient bit per stage, then saturation.
module prf_div import prf_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire div_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [ACC_W-1:0] out_acc_o,
  output logic             out_in_range_o
);

  localparam int unsigned NSTEP = ACC_W;
  localparam int unsigned CMP_W = DEN_W + PLOW_W;

  logic             en;
  logic             v0_q;
  logic [NSTEP-1:0] v_q;
  logic             vs_q;
  div_st_t          init_d, st0_q;
  div_st_t          st_in [NSTEP];
  div_st_t          st_q [NSTEP];
  logic [ACC_W-1:0] acc_q;
  logic             rng_q;

  assign en = !vs_q || out_ready_i;
  assign in_ready_o = en;
  assign out_valid_o = vs_q;
  assign out_acc_o = acc_q;
  assign out_in_range_o = rng_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v_q <= '0;
      vs_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v_q <= {v_q[NSTEP-2:0], v0_q};
      vs_q <= v_q[NSTEP-1];
    end
  end

  // A quotient of 2^64 or more is flagged; otherwise the upper bits
  // of the numerator form the starting remainder.
  always_comb begin
    init_d.ovf = CMP_W'(in_data_i.p) >= {in_data_i.den, {PLOW_W{1'b0}}};
    init_d.rem = DEN_W'(in_data_i.p[PROD_W-1:PLOW_W]);
    init_d.plow = in_data_i.p[PLOW_W-1:0];
    init_d.den = in_data_i.den;
    init_d.q = '0;
    init_d.neg = in_data_i.neg;
    init_d.in_range = in_data_i.in_range;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st0_q <= init_d;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign st_in[k] = st0_q;
    end else begin : g_next
      assign st_in[k] = st_q[k-1];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        st_q[k] <= div_step(st_in[k]);
      end
    end
  end

  // Output register: sign, saturation and the out-of-range zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= sat_acc(st_q[NSTEP-1]);
      rng_q <= st_q[NSTEP-1].in_range;
    end
  end

endmodule

`default_nettype wire

[rtl/core/prf_checker.sv]
`default_nettype none

// Port-level checks on the result channel.
module prf_checker import prf_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire logic [ACC_W-1:0] accel_x_i,
  input wire logic [ACC_W-1:0] accel_y_i,
  input wire logic             within_cutoff_i
);

  // A result that is not taken stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result withdrawn before transfer");

  // Pairs beyond the cutoff carry no force.
  a_far_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !within_cutoff_i |-> (accel_x_i == '0) && (accel_y_i == '0))
    else $error("nonzero force for a pair beyond the cutoff");

  // Nothing is offered right after reset.
  a_reset_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result offered straight out of reset");

endmodule

bind pair_repulsive_force_core prf_checker u_prf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .accel_x_i       (out_ch.accel_x),
  .accel_y_i       (out_ch.accel_y),
  .within_cutoff_i (out_ch.within_cutoff)
);

`default_nettype wire
